// ===== hw/rtl/vpr_pkg.sv =====
// Shared constants for the vanishing point residual block.
`default_nettype none
package vpr_pkg;

   // Register indexes on the configuration port
   localparam logic [3:0] CSR_FINITE_THRESHOLD = 4'd0;
   localparam logic [3:0] CSR_NEAR_RADIUS      = 4'd1;
   localparam logic [3:0] CSR_PROBE_DISTANCE   = 4'd2;
   localparam logic [3:0] CSR_PENALTY_VALUE    = 4'd3;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 48;

   localparam logic [15:0] FINITE_THRESHOLD_RST = 16'd66;
   localparam logic [22:0] NEAR_RADIUS_RST      = 23'd1280;
   localparam logic [11:0] PROBE_DISTANCE_RST   = 12'd100;
   localparam logic [47:0] PENALTY_VALUE_RST    = 48'd2560000;

   localparam logic [47:0] RESIDUE_MAX = 48'hFFFF_FFFF_FFFF;

   // Register stages from input transfer to output register
   localparam int LATENCY = 47;

endpackage
`default_nettype wire

// ===== hw/rtl/vpr_mul.sv =====
// Unsigned wide multiplier cut into four partial products, three register stages.
`default_nettype none
module vpr_mul #(
   parameter int AW = 58,
   parameter int BW = 58
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [AW-1:0]     a,
   input  wire logic [BW-1:0]     b,
   output logic      [AW+BW-1:0]  p
);
   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] p00_ff;
   logic [AL+BH-1:0] p01_ff;
   logic [AH+BL-1:0] p10_ff;
   logic [AH+BH-1:0] p11_ff;
   logic [PW-1:0]    lo_ff;
   logic [PW-1:0]    hi_ff;
   logic [PW-1:0]    p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
         p01_ff <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
         p10_ff <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
         p11_ff <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
         lo_ff  <= PW'(p00_ff) + (PW'(p01_ff) << BL);
         hi_ff  <= (PW'(p11_ff) << (AL + BL)) + (PW'(p10_ff) << AL);
         p_ff   <= lo_ff + hi_ff;
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/vpr_delay.sv =====
// Enabled shift line that keeps side data in step with the pipeline.
`default_nettype none
module vpr_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] d,
   output logic      [W-1:0] q
);
   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/vpr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, ratio clamped to one.
`default_nettype none
module vpr_div #(
   parameter int NW = 114,
   parameter int DW = 112,
   parameter int QW = 32
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic      [QW:0]   quo
);
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ge_ff  [QW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num[DW-1:0];
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ge_ff[0]  <= (num >= NW'(den));
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [DW:0] sh;
      logic        take;
      assign sh   = {rem_ff[j-1], 1'b0};
      assign take = (sh >= {1'b0, den_ff[j-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]  <= {q_ff[j-1][QW-2:0], take};
            ge_ff[j] <= ge_ff[j-1];
         end
      end

      if (j < QW) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= take ? DW'(sh - {1'b0, den_ff[j-1]}) : sh[DW-1:0];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quo = ge_ff[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, q_ff[QW]};

endmodule
`default_nettype wire

// ===== hw/rtl/vanishing_point_residual.sv =====
// Top level: vanishing point residual for one line segment, fully pipelined.
//
// Usage
// - Input channel req_*: one segment (Q16.8 start/end) and one homogeneous
//   vanishing point (Q16.16) per transfer on req_valid/req_ready.
// - Result channel rsp_*: one residue (Q40.8 px^2) with near_hit and
//   degenerate flags per input transfer, in input order.
// - csr_*: write-only registers, index per vpr_pkg, taken on csr_we.
//   Write only while no item is in flight.
// Timing
// - 47 register stages; rsp_valid is the valid bit of the last stage, and
//   the result transfer takes place when rsp_ready is also high.
// - Throughput is one item per cycle while the pipeline is not held. The depth
//   comes mostly from the 32 stage quotient pipeline (one bit per stage) plus the split wide multipliers.
// Reset and stall
// - reset clears all stage valid bits and reloads the register defaults.
// - When the receiver holds rsp_ready low with a result waiting, the whole
//   pipeline holds and req_ready drops in the same cycle; nothing is lost.
`default_nettype none
module vanishing_point_residual
   import vpr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [23:0]      req_start_x,
   input  wire logic signed [23:0]      req_start_y,
   input  wire logic signed [23:0]      req_end_x,
   input  wire logic signed [23:0]      req_end_y,
   input  wire logic signed [31:0]      req_vp_x,
   input  wire logic signed [31:0]      req_vp_y,
   input  wire logic signed [31:0]      req_vp_w,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [47:0]                  rsp_residue,
   output logic                         rsp_near_hit,
   output logic                         rsp_degenerate,
   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Bit length of a magnitude; drives the normal shrink amount
   function automatic logic [5:0] bit_len(input logic [57:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 58; i++) begin
         if (v[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

   // Configuration registers
   logic [15:0] thr_ff;
   logic [22:0] rad_ff;
   logic [11:0] probe_ff;
   logic [47:0] pen_ff;
   logic [23:0] pd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= FINITE_THRESHOLD_RST;
         rad_ff   <= NEAR_RADIUS_RST;
         probe_ff <= PROBE_DISTANCE_RST;
         pen_ff   <= PENALTY_VALUE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FINITE_THRESHOLD: thr_ff   <= csr_wdata[15:0];
            CSR_NEAR_RADIUS:      rad_ff   <= csr_wdata[22:0];
            CSR_PROBE_DISTANCE:   probe_ff <= csr_wdata[11:0];
            CSR_PENALTY_VALUE:    pen_ff   <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   // Probe distance squared, registered; settles long before a new item reaches stage 46, where it is used
   always_ff @(posedge clock) begin
      pd2_ff <= 24'(probe_ff) * 24'(probe_ff);
   end

   // Stage valid bits; the whole pipe advances together
   logic [LATENCY:1] vld_ff;
   logic             adv;

   assign adv       = !vld_ff[LATENCY] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-1:1], req_valid};
      end
   end

   // Stage 1: midpoint (x2), direction, |w|
   logic signed [24:0] mx1_ff, my1_ff, dx1_ff, dy1_ff;
   logic signed [31:0] vx1_ff, vy1_ff, vw1_ff;
   logic [31:0]        wmag1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx1_ff   <= 25'(req_start_x) + 25'(req_end_x);
         my1_ff   <= 25'(req_start_y) + 25'(req_end_y);
         dx1_ff   <= 25'(req_end_x) - 25'(req_start_x);
         dy1_ff   <= 25'(req_end_y) - 25'(req_start_y);
         vx1_ff   <= req_vp_x;
         vy1_ff   <= req_vp_y;
         vw1_ff   <= req_vp_w;
         wmag1_ff <= req_vp_w[31] ? 32'(-req_vp_w) : 32'(req_vp_w);
      end
   end

   // Stage 2: M*w products, radius scale, direction squares
   logic signed [56:0] mxvw2_ff, myvw2_ff;
   logic signed [31:0] vx2_ff, vy2_ff;
   logic [54:0]        rr02_ff;
   logic [49:0]        dxx2_ff, dyy2_ff;
   logic               fin2_ff, dz2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mxvw2_ff <= 57'(mx1_ff) * 57'(vw1_ff);
         myvw2_ff <= 57'(my1_ff) * 57'(vw1_ff);
         vx2_ff   <= vx1_ff;
         vy2_ff   <= vy1_ff;
         rr02_ff  <= 55'(rad_ff) * 55'(wmag1_ff);
         dxx2_ff  <= 50'(50'(dx1_ff) * 50'(dx1_ff));
         dyy2_ff  <= 50'(50'(dy1_ff) * 50'(dy1_ff));
         fin2_ff  <= (wmag1_ff > 32'(thr_ff));
         dz2_ff   <= (dx1_ff == '0) && (dy1_ff == '0);
      end
   end

   // Stage 3: E = 512*vp - M*w, doubled radius, |d|^2
   logic signed [57:0] enx3_ff, eny3_ff;
   logic [55:0]        rr3_ff;
   logic [50:0]        dd3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         enx3_ff <= (58'(vx2_ff) <<< 9) - 58'(mxvw2_ff);
         eny3_ff <= (58'(vy2_ff) <<< 9) - 58'(myvw2_ff);
         rr3_ff  <= {rr02_ff, 1'b0};
         dd3_ff  <= 51'(dxx2_ff) + 51'(dyy2_ff);
      end
   end

   // Stage 4: magnitudes and signs of E
   logic [57:0] amx4_ff, amy4_ff;
   logic        snx4_ff, sny4_ff;
   logic [55:0] rr4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         amx4_ff <= enx3_ff[57] ? 58'(-enx3_ff) : 58'(enx3_ff);
         amy4_ff <= eny3_ff[57] ? 58'(-eny3_ff) : 58'(eny3_ff);
         snx4_ff <= enx3_ff[57];
         sny4_ff <= eny3_ff[57];
         rr4_ff  <= rr3_ff;
      end
   end

   // Near test squares, ready at stage 7
   logic [115:0] sqx7, sqy7;
   logic [111:0] rsq7;

   vpr_mul #(.AW(58), .BW(58)) u_sqx (
      .clock(clock), .en(adv), .a(amx4_ff), .b(amx4_ff), .p(sqx7)
   );
   vpr_mul #(.AW(58), .BW(58)) u_sqy (
      .clock(clock), .en(adv), .a(amy4_ff), .b(amy4_ff), .p(sqy7)
   );
   vpr_mul #(.AW(56), .BW(56)) u_rsq (
      .clock(clock), .en(adv), .a(rr4_ff), .b(rr4_ff), .p(rsq7)
   );

   // Stage 5: shrink amount so both normal components fall below 2^30
   logic [5:0]  blen4;
   logic [4:0]  k5_ff;
   logic        nz5_ff;
   logic [57:0] amx5_ff, amy5_ff;
   logic        snx5_ff, sny5_ff;

   assign blen4 = bit_len(amx4_ff | amy4_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         k5_ff   <= (blen4 > 6'd30) ? 5'(blen4 - 6'd30) : 5'd0;
         nz5_ff  <= ((amx4_ff | amy4_ff) != '0);
         amx5_ff <= amx4_ff;
         amy5_ff <= amy4_ff;
         snx5_ff <= snx4_ff;
         sny5_ff <= sny4_ff;
      end
   end

   // Stage 6: normal n = (Ey, -Ex), truncated toward zero
   logic [29:0]        mnx5, mny5;
   logic [29:0]        mnx6_ff, mny6_ff;
   logic signed [30:0] na6_ff, nb6_ff;

   assign mnx5 = 30'(amx5_ff >> k5_ff);
   assign mny5 = 30'(amy5_ff >> k5_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         mnx6_ff <= mnx5;
         mny6_ff <= mny5;
         na6_ff  <= sny5_ff ? -$signed({1'b0, mny5}) : $signed({1'b0, mny5});
         nb6_ff  <= snx5_ff ? $signed({1'b0, mnx5}) : -$signed({1'b0, mnx5});
      end
   end

   // Direction aligned with the normal
   logic [49:0]        dxy6;
   logic signed [24:0] dx6, dy6;

   vpr_delay #(.W(50), .N(5)) u_dly_d (
      .clock(clock), .en(adv), .d({dx1_ff, dy1_ff}), .q(dxy6)
   );
   assign dx6 = $signed(dxy6[49:25]);
   assign dy6 = $signed(dxy6[24:0]);

   // Stage 7: n.d products and |n|^2 terms
   logic signed [55:0] pa7_ff, pb7_ff;
   logic [59:0]        nna7_ff, nnb7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa7_ff  <= 56'(na6_ff) * 56'(dx6);
         pb7_ff  <= 56'(nb6_ff) * 56'(dy6);
         nna7_ff <= 60'(mny6_ff) * 60'(mny6_ff);
         nnb7_ff <= 60'(mnx6_ff) * 60'(mnx6_ff);
      end
   end

   // Stage 8: dot, |n|^2, near-test left side
   logic signed [56:0] dot8_ff;
   logic [60:0]        nn8_ff;
   logic [116:0]       lhs8_ff;
   logic [111:0]       rsq8_ff;
   logic               fin8;

   always_ff @(posedge clock) begin
      if (adv) begin
         dot8_ff <= 57'(pa7_ff) + 57'(pb7_ff);
         nn8_ff  <= 61'(nna7_ff) + 61'(nnb7_ff);
         lhs8_ff <= 117'(sqx7) + 117'(sqy7);
         rsq8_ff <= rsq7;
      end
   end

   vpr_delay #(.W(1), .N(6)) u_dly_fin (
      .clock(clock), .en(adv), .d(fin2_ff), .q(fin8)
   );

   // Stage 9: near decision, |dot|
   logic        near9_ff;
   logic [56:0] adot9_ff;
   logic [60:0] nn9_ff;
   logic [50:0] dd9;

   always_ff @(posedge clock) begin
      if (adv) begin
         near9_ff <= fin8 && (lhs8_ff < 117'(rsq8_ff));
         adot9_ff <= dot8_ff[56] ? 57'(-dot8_ff) : 57'(dot8_ff);
         nn9_ff   <= nn8_ff;
      end
   end

   vpr_delay #(.W(51), .N(6)) u_dly_dd (
      .clock(clock), .en(adv), .d(dd3_ff), .q(dd9)
   );

   // Ratio operands, ready at stage 12
   logic [113:0] num12;
   logic [111:0] den12;

   vpr_mul #(.AW(57), .BW(57)) u_num (
      .clock(clock), .en(adv), .a(adot9_ff), .b(adot9_ff), .p(num12)
   );
   vpr_mul #(.AW(61), .BW(51)) u_den (
      .clock(clock), .en(adv), .a(nn9_ff), .b(dd9), .p(den12)
   );

   // Ratio as Q1.32, ready at stage 45
   logic [32:0] c45;

   vpr_div #(.NW(114), .DW(112), .QW(32)) u_div (
      .clock(clock), .en(adv), .num(num12), .den(den12), .quo(c45)
   );

   // Flags aligned with stage 46
   logic near46, dz46, nz46;

   vpr_delay #(.W(1), .N(37)) u_dly_near (
      .clock(clock), .en(adv), .d(near9_ff), .q(near46)
   );
   vpr_delay #(.W(1), .N(44)) u_dly_dz (
      .clock(clock), .en(adv), .d(dz2_ff), .q(dz46)
   );
   vpr_delay #(.W(1), .N(41)) u_dly_nz (
      .clock(clock), .en(adv), .d(nz5_ff), .q(nz46)
   );

   // Stage 46: scale by probe distance squared
   logic [56:0] prod46_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod46_ff <= 57'(pd2_ff) * 57'(c45);
      end
   end

   // Stage 47: round half up, pick penalty, saturation or rounded value, hold on stall
   logic [56:0] rnd46;
   logic [47:0] rsp_residue_ff;
   logic        rsp_near_hit_ff, rsp_degenerate_ff;

   assign rnd46 = (prod46_ff + (57'd1 << 23)) >> 24;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (near46) begin
            rsp_residue_ff    <= pen_ff;
            rsp_near_hit_ff   <= 1'b1;
            rsp_degenerate_ff <= 1'b0;
         end else if (dz46 || !nz46) begin
            rsp_residue_ff    <= RESIDUE_MAX;
            rsp_near_hit_ff   <= 1'b0;
            rsp_degenerate_ff <= 1'b1;
         end else begin
            rsp_residue_ff    <= rnd46[47:0];
            rsp_near_hit_ff   <= 1'b0;
            rsp_degenerate_ff <= 1'b0;
         end
      end
   end

   assign rsp_residue    = rsp_residue_ff;
   assign rsp_near_hit   = rsp_near_hit_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

endmodule
`default_nettype wire

// ===== tb/vanishing_point_residual_tb.sv =====
// Testbench for the vanishing point residual block: random and directed segments, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module vanishing_point_residual_tb
   import vpr_pkg::*;
();

   // Index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_INDEX = 4'd9;

   // One segment and one homogeneous vanishing point
   typedef struct {
      logic signed [23:0] start_x, start_y, end_x, end_y;
      logic signed [31:0] vp_x, vp_y, vp_w;
   } segment_type;

   // One residue with its flags
   typedef struct {
      logic [47:0] residue;
      logic        near_hit;
      logic        degenerate;
   } residue_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [23:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic signed [31:0] req_vp_x, req_vp_y, req_vp_w;
   logic rsp_valid, rsp_ready;
   logic [47:0] rsp_residue;
   logic rsp_near_hit, rsp_degenerate;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   vanishing_point_residual uut (.*);

   // Shadow copies of the registers, kept in step with every write
   logic [15:0] shadow_threshold;
   logic [22:0] shadow_radius;
   logic [11:0] shadow_probe;
   logic [47:0] shadow_penalty;

   segment_type segment_q[$];
   residue_type residue_q[$];
   int error_count;
   int send_idle_pct, recv_stall_pct;
   bit req_taken;
   bit hold_start;
   int hold_left;

   function automatic logic [63:0] magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   // Compute the expected residue for one segment under the shadow registers
   function automatic residue_type predict_residue(segment_type s);
      residue_type r;
      longint sx, sy, ex, ey, vx, vy, vw, mx, my, enx, eny, dx, dy, na, nb, dot;
      logic [63:0] wmag, big, rr, ratio;
      logic [127:0] lhs, rhs, num, den;
      logic [159:0] quot;
      int k;
      sx = s.start_x; sy = s.start_y; ex = s.end_x; ey = s.end_y;
      vx = s.vp_x; vy = s.vp_y; vw = s.vp_w;
      mx = sx + ex; my = sy + ey;
      enx = vx * 512 - mx * vw;
      eny = vy * 512 - my * vw;
      dx = ex - sx; dy = ey - sy;
      wmag = magnitude(vw);
      r.residue = '0; r.near_hit = 1'b0; r.degenerate = 1'b0;
      // Finite point strictly inside the radius: penalty wins over everything
      if (wmag > 64'(shadow_threshold)) begin
         lhs = 128'(magnitude(enx)) * 128'(magnitude(enx))
             + 128'(magnitude(eny)) * 128'(magnitude(eny));
         rr = 64'd2 * 64'(shadow_radius) * wmag;
         rhs = 128'(rr) * 128'(rr);
         if (lhs < rhs) begin
            r.residue = shadow_penalty;
            r.near_hit = 1'b1;
            return r;
         end
      end
      na = eny; nb = -enx;
      big = magnitude(na) > magnitude(nb) ? magnitude(na) : magnitude(nb);
      if ((dx == 0 && dy == 0) || big == 0) begin
         r.residue = RESIDUE_MAX;
         r.degenerate = 1'b1;
         return r;
      end
      // Scale the normal down until both parts fit in 30 bits, truncating magnitudes
      k = 0;
      while ((big >> k) >= 64'd1 << 30) k++;
      na = na < 0 ? -longint'(magnitude(na) >> k) : longint'(magnitude(na) >> k);
      nb = nb < 0 ? -longint'(magnitude(nb) >> k) : longint'(magnitude(nb) >> k);
      dot = na * dx + nb * dy;
      num = 128'(magnitude(dot)) * 128'(magnitude(dot));
      den = 128'(64'(na * na + nb * nb)) * 128'(64'(dx * dx + dy * dy));
      if (num >= den) ratio = 64'd1 << 32;
      else begin
         quot = {num, 32'd0};
         quot = quot / 160'(den);
         ratio = quot[63:0];
      end
      r.residue = 48'((64'(shadow_probe) * 64'(shadow_probe) * ratio + (64'd1 << 23)) >> 24);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Driver: present the next pending segment at the falling edge; hold until transferred
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (segment_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_start_x <= segment_q[0].start_x;
            req_start_y <= segment_q[0].start_y;
            req_end_x   <= segment_q[0].end_x;
            req_end_y   <= segment_q[0].end_y;
            req_vp_x    <= segment_q[0].vp_x;
            req_vp_y    <= segment_q[0].vp_y;
            req_vp_w    <= segment_q[0].vp_w;
            void'(segment_q.pop_front());
         end else
            req_valid <= 1'b0;
      end
   end

   // Receiver: random stalls, forced low during a hold-off
   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Hold-off counter for the back-pressure stretch
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = 400;
         hold_start = 1'b0;
      end else if (hold_left > 0)
         hold_left = hold_left - 1;
   end

   // Monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      segment_type s;
      residue_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            s.start_x = req_start_x; s.start_y = req_start_y;
            s.end_x = req_end_x; s.end_y = req_end_y;
            s.vp_x = req_vp_x; s.vp_y = req_vp_y; s.vp_w = req_vp_w;
            residue_q.push_back(predict_residue(s));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (residue_q.size() == 0)
               report_mismatch("unexpected result", rsp_residue, 48'd0);
            else begin
               want = residue_q.pop_front();
               if (rsp_residue !== want.residue)
                  report_mismatch("residue", rsp_residue, want.residue);
               if (rsp_near_hit !== want.near_hit)
                  report_mismatch("near_hit", 48'(rsp_near_hit), 48'(want.near_hit));
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", 48'(rsp_degenerate), 48'(want.degenerate));
            end
         end
      end
   end

   // Write one register while idle and update the shadow copy
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [47:0] value);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      case (idx)
         CSR_FINITE_THRESHOLD: shadow_threshold = value[15:0];
         CSR_NEAR_RADIUS:      shadow_radius = value[22:0];
         CSR_PROBE_DISTANCE:   shadow_probe = value[11:0];
         CSR_PENALTY_VALUE:    shadow_penalty = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every pending segment is transferred and every result checked
   task automatic drain();
      wait (segment_q.size() == 0 && !req_valid && residue_q.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Fields are given wide and cut to their widths
   function automatic segment_type make_segment(
      longint sx, sy, ex, ey, vx, vy, vw);
      segment_type s;
      s.start_x = 24'(sx); s.start_y = 24'(sy); s.end_x = 24'(ex); s.end_y = 24'(ey);
      s.vp_x = 32'(vx); s.vp_y = 32'(vy); s.vp_w = 32'(vw);
      return s;
   endfunction

   // Random segment: mostly a point placed near or on the midpoint line, some raw noise
   function automatic segment_type random_segment();
      segment_type s;
      longint w, mx, my;
      int pick;
      pick = $urandom_range(99);
      s = make_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (pick < 55) begin
         // Compact segment with a point close to its midpoint at a modest scale
         s.start_x = 24'($signed($urandom_range(131071)) - 65536);
         s.start_y = 24'($signed($urandom_range(131071)) - 65536);
         s.end_x = 24'(s.start_x + $signed($urandom_range(8191)) - 4096);
         s.end_y = 24'(s.start_y + $signed($urandom_range(8191)) - 4096);
         w = longint'($urandom_range(65535));
         if ($urandom_range(1)) w = -w;
         mx = longint'(s.start_x) + longint'(s.end_x);
         my = longint'(s.start_y) + longint'(s.end_y);
         s.vp_x = 32'(((mx * w) >>> 9) + $urandom_range(4000) - 2000);
         s.vp_y = 32'(((my * w) >>> 9) + $urandom_range(4000) - 2000);
         s.vp_w = 32'(w);
      end else if (pick < 65) begin
         s.end_x = s.start_x; s.end_y = s.start_y;
      end else if (pick < 70) begin
         s.vp_x = '0; s.vp_y = '0; s.vp_w = '0;
      end else if (pick < 80) begin
         // Point at infinity or close to it
         s.vp_w = $signed($urandom_range(200)) - 100;
      end
      return s;
   endfunction

   task automatic run_phase(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) segment_q.push_back(random_segment());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; rsp_ready = 1'b0;
      req_start_x = '0; req_start_y = '0; req_end_x = '0; req_end_y = '0;
      req_vp_x = '0; req_vp_y = '0; req_vp_w = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_taken = 1'b0; hold_start = 1'b0; hold_left = 0;
      error_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
      shadow_threshold = FINITE_THRESHOLD_RST;
      shadow_radius = NEAR_RADIUS_RST;
      shadow_probe = PROBE_DISTANCE_RST;
      shadow_penalty = PENALTY_VALUE_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset registers, field extremes and each special case
      segment_q.push_back(make_segment(0, 0, 2560, 0, 327680, 0, 65536));   // penalty
      segment_q.push_back(make_segment(0, 0, 2560, 0, 330, 0, 66));         // not finite, zero normal
      segment_q.push_back(make_segment(100, 200, 100, 200, 5000, 7, 65536)); // zero length
      segment_q.push_back(make_segment(-5, 9, 300, 40, 0, 0, 0));            // point all zero
      segment_q.push_back(make_segment(24'h7FFFFF, 24'h7FFFFF, 24'sh800000, 24'sh800000,
                                       32'h7FFFFFFF, 32'sh80000000, 32'h7FFFFFFF));
      segment_q.push_back(make_segment(24'sh800000, 24'h7FFFFF, 24'h7FFFFF, 24'sh800000,
                                       32'sh80000000, 32'h7FFFFFFF, 32'sh80000000));
      segment_q.push_back(make_segment(0, 0, 2560, 0, 65536, 0, 0));        // horizontal line
      segment_q.push_back(make_segment(0, 0, 2560, 0, 0, 65536, 0));        // perpendicular
      segment_q.push_back(make_segment(-1, -1, 1, 1, 1, -1, 0));
      segment_q.push_back(make_segment(0, 0, 2560, 0, 327680, 200000, 65536)); // inside radius, penalty
      segment_q.push_back(make_segment(0, 0, 2560, 0, -327680, 0, -65536)); // negative w, near
      segment_q.push_back(make_segment(0, 0, 1, 0, 0, 1, 67));
      drain();

      // Zero radius: penalty never fires, exact point on midpoint gives a zero normal
      write_reg(CSR_NEAR_RADIUS, 48'd0);
      write_reg(CSR_FINITE_THRESHOLD, 48'd0);
      write_reg(CSR_PROBE_DISTANCE, 48'd4095);
      write_reg(CSR_PENALTY_VALUE, RESIDUE_MAX);
      segment_q.push_back(make_segment(0, 0, 2560, 0, 2560, 0, 512));
      segment_q.push_back(make_segment(0, 0, 2560, 0, 327680, 0, 65536));
      segment_q.push_back(make_segment(7, -3, 900, 45, 1, 1, 1));
      drain();

      // Random phases across register settings and idle patterns
      run_phase(150, 0, 0);
      write_reg(CSR_NEAR_RADIUS, 48'h7FFFFF);
      write_reg(CSR_FINITE_THRESHOLD, 48'hFFFF);
      write_reg(CSR_PROBE_DISTANCE, 48'd1);
      write_reg(CSR_PENALTY_VALUE, 48'd0);
      write_reg(CSR_UNMAPPED_INDEX, 48'h1234);   // unmapped index, dropped
      run_phase(150, 75, 0);
      write_reg(CSR_NEAR_RADIUS, 48'd1280);
      write_reg(CSR_FINITE_THRESHOLD, 48'd66);
      write_reg(CSR_PROBE_DISTANCE, 48'd100);
      write_reg(CSR_PENALTY_VALUE, 48'd2560000);
      run_phase(150, 0, 75);
      write_reg(CSR_NEAR_RADIUS, 48'd40000);
      write_reg(CSR_PROBE_DISTANCE, 48'd777);
      run_phase(150, 30, 30);

      // Back-pressure: hold the receiver off while the sender keeps offering
      hold_start = 1'b1;
      run_phase(150, 0, 0);
      write_reg(CSR_NEAR_RADIUS, 48'd5000000);
      write_reg(CSR_FINITE_THRESHOLD, 48'd1000);
      write_reg(CSR_PROBE_DISTANCE, 48'd4095);
      write_reg(CSR_PENALTY_VALUE, 48'h800000000001);
      run_phase(180, 30, 30);

      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && residue_q.size() == 0)
         $display("vanishing_point_residual_tb: clean");
      else
         $display("vanishing_point_residual_tb: errors");
      $finish;
   end

   // Stop a hung run
   initial begin
      #60_000_000;
      $display("vanishing_point_residual_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire
